>>> hdl/ufe_pkg.sv
// ufe_pkg: shared types and constants of the disjoint-set engine
// used by the channel interfaces and by union_find_engine

package ufe_pkg;

   localparam int ELEMENTS_DEF = 1024;  // default table depth
   localparam int FIELD_W      = 10;    // element index field width
   localparam int REQ_W        = 2;     // request code width

   // request codes, the unused code behaves as find
   localparam logic [REQ_W-1:0] REQ_FIND = 2'd0;
   localparam logic [REQ_W-1:0] REQ_SAME = 2'd1;
   localparam logic [REQ_W-1:0] REQ_JOIN = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK_A,
      ST_WALK_B,
      ST_SIZE_A,
      ST_SIZE_B,
      ST_RESP
   } state_type;

endpackage

>>> hdl/ufe_ifs.sv
// ufe_ifs: valid/ready channel interfaces of the disjoint-set engine
// depends on ufe_pkg for the field widths

interface ufe_req_if;
   logic                        valid;
   logic                        ready;
   logic [ufe_pkg::REQ_W-1:0]   req_type;
   logic [ufe_pkg::FIELD_W-1:0] elem_a;
   logic [ufe_pkg::FIELD_W-1:0] elem_b;

   modport source (output valid, req_type, elem_a, elem_b, input ready);
   modport sink   (input valid, req_type, elem_a, elem_b, output ready);
endinterface

interface ufe_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ufe_pkg::FIELD_W-1:0] root_a;
   logic [ufe_pkg::FIELD_W-1:0] root_b;
   logic                        same_set;
   logic                        merged;

   modport source (output valid, root_a, root_b, same_set, merged, input ready);
   modport sink   (input valid, root_a, root_b, same_set, merged, output ready);
endinterface

>>> hdl/union_find_engine.sv
// union_find_engine: disjoint-set table with union by size, no path compression
// depends on ufe_pkg and the channel interfaces in ufe_ifs
//
//  channel   dir  payload                              handshake
//  req_bus   in   req_type, elem_a, elem_b             valid/ready
//  rsp_bus   out  root_a, root_b, same_set, merged     valid/ready
//
// one item at a time: accept, walk elem_a to its root, and for same/join walk
// elem_b to its root, then a size read and link for a real join, and last the
// load of the result register; both walks go over the single read port of the
// parent memory
// after reset a clearing pass fills the parent and size memories; no item is
// taken meanwhile
// a result waiting in the output register does not block the next item, only
// the load of the following result waits for rsp_bus.ready

module union_find_engine #(
   parameter int ELEMENTS = ufe_pkg::ELEMENTS_DEF
) (
   input logic       clock,
   input logic       reset,
   ufe_req_if.sink   req_bus,
   ufe_rsp_if.source rsp_bus
);

   localparam int IDX_W = $clog2(ELEMENTS);
   localparam int SZ_W  = $clog2(ELEMENTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMENTS - 1);

   logic [IDX_W-1:0] parent_mem [ELEMENTS];
   logic [SZ_W-1:0]  size_mem   [ELEMENTS];

   ufe_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]         clr_ff, clr_in;
   logic [ufe_pkg::REQ_W-1:0] type_ff, type_in;
   logic [IDX_W-1:0]         cur_ff, cur_in;
   logic [IDX_W-1:0]         b_ff, b_in;
   logic [IDX_W-1:0]         ra_ff, ra_in;
   logic [IDX_W-1:0]         rb_ff, rb_in;
   logic                     same_ff, same_in;
   logic                     merged_ff, merged_in;
   logic [SZ_W-1:0]          sa_ff, sa_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ufe_pkg::FIELD_W-1:0] rsp_ra_ff, rsp_ra_in;
   logic [ufe_pkg::FIELD_W-1:0] rsp_rb_ff, rsp_rb_in;
   logic                        rsp_same_ff, rsp_same_in;
   logic                        rsp_merged_ff, rsp_merged_in;

   logic [IDX_W-1:0] par_rd_ff;
   logic [SZ_W-1:0]  sz_rd_ff;
   logic [IDX_W-1:0] par_addr, par_waddr, par_wdata;
   logic [IDX_W-1:0] sz_addr, sz_waddr;
   logic [SZ_W-1:0]  sz_wdata;
   logic             par_we, sz_we;

   logic [IDX_W-1:0] a_idx, b_idx;
   logic             keep_a, is_pair;

   // out of range indices saturate to the last element
   always_comb begin
      a_idx = (32'(req_bus.elem_a) >= 32'(ELEMENTS)) ? LAST_IDX : IDX_W'(req_bus.elem_a);
      b_idx = (32'(req_bus.elem_b) >= 32'(ELEMENTS)) ? LAST_IDX : IDX_W'(req_bus.elem_b);
   end

   assign is_pair = (type_ff == ufe_pkg::REQ_SAME) || (type_ff == ufe_pkg::REQ_JOIN);

   // element 0 always survives, else the larger set, ties keep root of a
   assign keep_a = (ra_ff == '0) || ((rb_ff != '0) && !(sa_ff < sz_rd_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ufe_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      cur_ff        <= cur_in;
      b_ff          <= b_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      same_ff       <= same_in;
      merged_ff     <= merged_in;
      sa_ff         <= sa_in;
      rsp_ra_ff     <= rsp_ra_in;
      rsp_rb_ff     <= rsp_rb_in;
      rsp_same_ff   <= rsp_same_in;
      rsp_merged_ff <= rsp_merged_in;
   end

   // parent and size memories, one read and one write port each
   always_ff @(posedge clock) begin
      par_rd_ff <= parent_mem[par_addr];
      if (par_we) begin
         parent_mem[par_waddr] <= par_wdata;
      end
   end

   always_ff @(posedge clock) begin
      sz_rd_ff <= size_mem[sz_addr];
      if (sz_we) begin
         size_mem[sz_waddr] <= sz_wdata;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      type_in       = type_ff;
      cur_in        = cur_ff;
      b_in          = b_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      same_in       = same_ff;
      merged_in     = merged_ff;
      sa_in         = sa_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_ra_in     = rsp_ra_ff;
      rsp_rb_in     = rsp_rb_ff;
      rsp_same_in   = rsp_same_ff;
      rsp_merged_in = rsp_merged_ff;
      req_bus.ready = 1'b0;
      par_addr      = cur_ff;
      par_we        = 1'b0;
      par_waddr     = clr_ff;
      par_wdata     = clr_ff;
      sz_addr       = ra_ff;
      sz_we         = 1'b0;
      sz_waddr      = clr_ff;
      sz_wdata      = SZ_W'(1);

      unique case (state_ff)
         ufe_pkg::ST_CLEAR: begin
            par_we = 1'b1;
            sz_we  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = ufe_pkg::ST_IDLE;
            end
         end
         ufe_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            par_addr      = a_idx;
            if (req_bus.valid) begin
               type_in   = req_bus.req_type;
               cur_in    = a_idx;
               b_in      = b_idx;
               rb_in     = '0;
               same_in   = 1'b0;
               merged_in = 1'b0;
               state_in  = ufe_pkg::ST_WALK_A;
            end
         end
         ufe_pkg::ST_WALK_A: begin
            // one parent link per cycle, a self link marks the root
            if (par_rd_ff == cur_ff) begin
               ra_in = cur_ff;
               if (is_pair) begin
                  par_addr = b_ff;
                  cur_in   = b_ff;
                  state_in = ufe_pkg::ST_WALK_B;
               end else begin
                  state_in = ufe_pkg::ST_RESP;
               end
            end else begin
               par_addr = par_rd_ff;
               cur_in   = par_rd_ff;
            end
         end
         ufe_pkg::ST_WALK_B: begin
            if (par_rd_ff == cur_ff) begin
               rb_in   = cur_ff;
               same_in = (ra_ff == cur_ff);
               sz_addr = ra_ff;
               if (type_ff == ufe_pkg::REQ_JOIN && ra_ff != cur_ff) begin
                  state_in = ufe_pkg::ST_SIZE_A;
               end else begin
                  state_in = ufe_pkg::ST_RESP;
               end
            end else begin
               par_addr = par_rd_ff;
               cur_in   = par_rd_ff;
            end
         end
         ufe_pkg::ST_SIZE_A: begin
            sa_in    = sz_rd_ff;
            sz_addr  = rb_ff;
            state_in = ufe_pkg::ST_SIZE_B;
         end
         ufe_pkg::ST_SIZE_B: begin
            par_we    = 1'b1;
            par_waddr = keep_a ? rb_ff : ra_ff;
            par_wdata = keep_a ? ra_ff : rb_ff;
            sz_we     = 1'b1;
            sz_waddr  = keep_a ? ra_ff : rb_ff;
            sz_wdata  = sa_ff + sz_rd_ff;
            merged_in = 1'b1;
            state_in  = ufe_pkg::ST_RESP;
         end
         ufe_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_ra_in     = ufe_pkg::FIELD_W'(ra_ff);
               rsp_rb_in     = ufe_pkg::FIELD_W'(rb_ff);
               rsp_same_in   = same_ff;
               rsp_merged_in = merged_ff;
               state_in      = ufe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ufe_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.root_a   = rsp_ra_ff;
   assign rsp_bus.root_b   = rsp_rb_ff;
   assign rsp_bus.same_set = rsp_same_ff;
   assign rsp_bus.merged   = rsp_merged_ff;

   // a link only joins two distinct roots
   a_link_distinct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ufe_pkg::ST_SIZE_B) |-> (ra_ff != rb_ff))
      else $error("link of a root to itself");

   // element 0 never goes under another root
   a_zero_stays_root: assert property (@(posedge clock) disable iff (reset)
      par_we && (state_ff == ufe_pkg::ST_SIZE_B) |-> (par_waddr != '0))
      else $error("element 0 linked under another root");

   // a merge never reports both elements in one set
   a_merge_not_same: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_merged_ff && rsp_same_ff))
      else $error("merged and same_set both set");

   // no item is taken while the tables are being cleared
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ufe_pkg::ST_CLEAR) |-> !req_bus.ready)
      else $error("item accepted during clearing pass");

   // a result is loaded only after the previous one left
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> rsp_valid_ff && $stable(rsp_ra_ff))
      else $error("pending item overwritten");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for union_find_engine, a directed table then random traffic
// depends on ufe_pkg, the channel interfaces in ufe_ifs and the engine rtl

module tb_top;
   import ufe_pkg::*;

   localparam int NODES        = ELEMENTS_DEF;
   localparam int SCRIPT_ROWS  = 23;
   localparam int RANDOM_ITEMS = 700;
   localparam int PAUSE_AT     = 300;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 200000;

   // the unused request code, handled as find
   localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

   typedef logic [FIELD_W-1:0] node_type;

   // element 0 never gets linked under another root
   localparam node_type ANCHOR = '0;

   typedef struct packed {
      node_type root_a;
      node_type root_b;
      logic     same_set;
      logic     merged;
   } lookup_type;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      node_type         elem_a;
      node_type         elem_b;
      logic             known;
      lookup_type       outcome;
   } script_row_type;

   localparam lookup_type UNTYPED = '0;

   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      '{REQ_FIND,  10'd0,    10'd0,    1'b1, '{10'd0,    10'd0,    1'b0, 1'b0}},
      '{REQ_FIND,  10'd1023, 10'd1023, 1'b1, '{10'd1023, 10'd0,    1'b0, 1'b0}},
      '{REQ_SAME,  10'd0,    10'd1023, 1'b1, '{10'd0,    10'd1023, 1'b0, 1'b0}},
      '{REQ_SAME,  10'd5,    10'd5,    1'b1, '{10'd5,    10'd5,    1'b1, 1'b0}},
      // equal sizes: second root goes under the first
      '{REQ_JOIN,  10'd1023, 10'd5,    1'b1, '{10'd1023, 10'd5,    1'b0, 1'b1}},
      '{REQ_JOIN,  10'd5,    10'd1023, 1'b1, '{10'd1023, 10'd1023, 1'b1, 1'b0}},
      // element 0 as smaller first operand keeps its root
      '{REQ_JOIN,  10'd0,    10'd1023, 1'b1, '{10'd0,    10'd1023, 1'b0, 1'b1}},
      '{REQ_FIND,  10'd5,    10'd0,    1'b1, '{10'd0,    10'd0,    1'b0, 1'b0}},
      '{REQ_SPARE, 10'd5,    10'd777,  1'b1, '{10'd0,    10'd0,    1'b0, 1'b0}},
      '{REQ_JOIN,  10'd512,  10'd0,    1'b1, '{10'd512,  10'd0,    1'b0, 1'b1}},
      '{REQ_JOIN,  10'd1,    10'd2,    1'b0, UNTYPED},
      '{REQ_JOIN,  10'd3,    10'd1,    1'b0, UNTYPED},
      '{REQ_JOIN,  10'd4,    10'd6,    1'b0, UNTYPED},
      '{REQ_JOIN,  10'd4,    10'd1,    1'b0, UNTYPED},
      '{REQ_FIND,  10'd6,    10'd0,    1'b0, UNTYPED},
      '{REQ_SAME,  10'd6,    10'd2,    1'b0, UNTYPED},
      '{REQ_JOIN,  10'd6,    10'd0,    1'b0, UNTYPED},
      '{REQ_SAME,  10'd1023, 10'd6,    1'b0, UNTYPED},
      '{REQ_JOIN,  10'd682,  10'd341,  1'b0, UNTYPED},
      '{REQ_SAME,  10'd341,  10'd682,  1'b0, UNTYPED},
      '{REQ_SPARE, 10'd1023, 10'd0,    1'b0, UNTYPED},
      '{REQ_JOIN,  10'd1022, 10'd1021, 1'b0, UNTYPED},
      '{REQ_FIND,  10'd1021, 10'd1023, 1'b0, UNTYPED}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   ufe_req_if req_if ();
   ufe_rsp_if rsp_if ();

   union_find_engine u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the parent links and set sizes
   node_type    chain_link [NODES];
   int unsigned set_count  [NODES];

   lookup_type pending_roots [$];
   int         mismatches = 0;
   int         cycles     = 0;

   function automatic node_type find_root(node_type start);
      node_type cur;
      int       hops;
      cur = start;
      for (hops = 0; hops < NODES; hops++) begin
         if (chain_link[cur] == cur) break;
         cur = chain_link[cur];
      end
      return cur;
   endfunction

   function automatic lookup_type resolve_request(logic [REQ_W-1:0] kind,
                                                  node_type a, node_type b);
      lookup_type res;
      node_type   keep;
      node_type   lose;
      res = '0;
      res.root_a = find_root(a);
      if (kind == REQ_SAME || kind == REQ_JOIN) begin
         res.root_b   = find_root(b);
         res.same_set = (res.root_a == res.root_b);
         if (kind == REQ_JOIN && !res.same_set) begin
            keep = res.root_a;
            lose = res.root_b;
            if (res.root_a == ANCHOR) begin
               keep = res.root_a;
            end else if (res.root_b == ANCHOR) begin
               keep = res.root_b;
               lose = res.root_a;
            end else if (set_count[res.root_a] < set_count[res.root_b]) begin
               keep = res.root_b;
               lose = res.root_a;
            end
            set_count[keep] += set_count[lose];
            chain_link[lose] = keep;
            res.merged = 1'b1;
         end
      end
      return res;
   endfunction

   // mostly a 64-element window so sets grow and trees get deep
   function automatic node_type pick_node(int base);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return node_type'(base + $urandom_range(0, 63));
      if (roll < 75) return node_type'($urandom_range(NODES - 64, NODES - 1));
      return node_type'($urandom_range(0, NODES - 1));
   endfunction

   task automatic offer_item(input logic [REQ_W-1:0] kind, input node_type a, input node_type b,
                             input bit calm, input logic known, input lookup_type outcome);
      int         gap;
      lookup_type predicted;
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= kind;
      req_if.elem_a   <= a;
      req_if.elem_b   <= b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predicted = resolve_request(kind, a, b);
      pending_roots.insert(pending_roots.size(), known ? outcome : predicted);
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("union_find_engine test failed");
         $finish;
      end
   end

   // result side: random stalls on ready, every item checked against the oldest queued expectation
   initial begin
      int         stall;
      int         taken;
      lookup_type want;
      taken = 0;
      rsp_if.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = ((taken / 50) % 3 == 1) ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         taken++;
         if (pending_roots.size() == 0) begin
            $error("unexpected item: root_a %0d root_b %0d", rsp_if.root_a, rsp_if.root_b);
            mismatches++;
         end else begin
            want = pending_roots.pop_front();
            if (rsp_if.root_a !== want.root_a) begin
               $error("root_a: expected %0d, got %0d", want.root_a, rsp_if.root_a);
               mismatches++;
            end
            if (rsp_if.root_b !== want.root_b) begin
               $error("root_b: expected %0d, got %0d", want.root_b, rsp_if.root_b);
               mismatches++;
            end
            if (rsp_if.same_set !== want.same_set) begin
               $error("same_set: expected %0d, got %0d", want.same_set, rsp_if.same_set);
               mismatches++;
            end
            if (rsp_if.merged !== want.merged) begin
               $error("merged: expected %0d, got %0d", want.merged, rsp_if.merged);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int               row;
      int               n;
      int               base;
      int               roll;
      logic [REQ_W-1:0] kind;
      req_if.valid    <= 1'b0;
      req_if.req_type <= REQ_FIND;
      req_if.elem_a   <= '0;
      req_if.elem_b   <= '0;
      for (n = 0; n < NODES; n++) begin
         chain_link[n] = node_type'(n);
         set_count[n]  = 1;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < SCRIPT_ROWS; row++) begin
         offer_item(SCRIPT[row].req_type, SCRIPT[row].elem_a, SCRIPT[row].elem_b,
                    row < 8, SCRIPT[row].known, SCRIPT[row].outcome);
      end

      base = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) base = $urandom_range(0, NODES / 64 - 1) * 64;
         // hold off until the engine has drained every outstanding item
         if (n == PAUSE_AT) begin
            req_if.valid <= 1'b0;
            do @(posedge clock); while (pending_roots.size() != 0);
         end
         roll = $urandom_range(0, 99);
         if (roll < 40)      kind = REQ_JOIN;
         else if (roll < 65) kind = REQ_SAME;
         else if (roll < 90) kind = REQ_FIND;
         else                kind = REQ_SPARE;
         offer_item(kind, pick_node(base), pick_node(base), (n / 40) % 4 == 3,
                    1'b0, UNTYPED);
      end
      req_if.valid <= 1'b0;

      while (pending_roots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("union_find_engine test passed");
      end else begin
         $display("union_find_engine test failed");
      end
      $finish;
   end

endmodule
